[rtl/esc_pkg.sv]
// Shared types, character codes and lookup functions for the escape decoder.
// Used by esc_decode, esc_fifo and escape_sequence_decoder; no dependencies.
package esc_pkg;

    // decode modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_SLASH = 2'd1;
    localparam logic [1:0] MODE_OCT   = 2'd2;
    localparam logic [1:0] MODE_HEX   = 2'd3;

    // characters with a role in the escape syntax
    localparam logic [7:0] CHAR_BSLASH = 8'h5c;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_SEVEN  = 8'h37;
    localparam logic [7:0] CHAR_X      = 8'h78;

    // octal and hex escapes take at most this many further digits
    localparam logic [1:0] DIGITS_MAX = 2'd2;
    localparam logic [11:0] VALUE_MAX = 12'd255;

    // decoder state
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] accum;
        logic [1:0] digits;
    } esc_state_t;

    localparam esc_state_t STATE_RESET = '{mode: MODE_PLAIN, accum: 8'd0, digits: 2'd0};

    // one result word
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       string_end;
    } esc_entry_t;

    // results of one input word, handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        esc_entry_t res0;
        esc_entry_t res1;
    } esc_push_t;

    // named escape: {valid, control code}
    function automatic logic [8:0] named_code(input logic [7:0] b);
        logic [8:0] r;
        begin
            case (b)
                8'h5c:   r = {1'b1, 8'h5c};
                8'h61:   r = {1'b1, 8'h07}; // a
                8'h62:   r = {1'b1, 8'h08}; // b
                8'h65:   r = {1'b1, 8'h1b}; // e
                8'h66:   r = {1'b1, 8'h0c}; // f
                8'h6e:   r = {1'b1, 8'h0a}; // n
                8'h72:   r = {1'b1, 8'h0d}; // r
                8'h74:   r = {1'b1, 8'h09}; // t
                8'h76:   r = {1'b1, 8'h0b}; // v
                default: r = {1'b0, 8'h00};
            endcase
            return r;
        end
    endfunction

    // hex digit: {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        begin
            if (b >= 8'h30 && b <= 8'h39)
                r = {1'b1, 4'(b - 8'h30)};
            else if (b >= 8'h61 && b <= 8'h66)
                r = {1'b1, 4'(b - 8'h57)};
            else if (b >= 8'h41 && b <= 8'h46)
                r = {1'b1, 4'(b - 8'h37)};
            else
                r = 5'd0;
            return r;
        end
    endfunction

endpackage

[rtl/esc_decode.sv]
// Combinational decode of one input word: next state and up to two results.
// Depends on esc_pkg.
module esc_decode
(
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  esc_pkg::esc_state_t st,
    output esc_pkg::esc_state_t st_next,
    output esc_pkg::esc_push_t  push
);

    logic [8:0]  named;
    logic [4:0]  hexd;
    logic        is_oct;
    logic        dig_ok;
    logic [3:0]  dig;
    logic [11:0] shifted;
    logic [11:0] sum;
    logic        take;
    logic [1:0]  digits_dec;
    esc_pkg::esc_state_t nxt;
    esc_pkg::esc_push_t  res;

    assign named = esc_pkg::named_code(in_byte);
    assign hexd  = esc_pkg::hex_value(in_byte);
    assign is_oct = (in_byte >= esc_pkg::CHAR_ZERO) && (in_byte <= esc_pkg::CHAR_SEVEN);

    // digit of the running escape and the value it would build
    always_comb
    begin
        if (st.mode == esc_pkg::MODE_OCT)
        begin
            dig_ok  = is_oct;
            dig     = {1'b0, in_byte[2:0]};
            shifted = {1'b0, st.accum, 3'b000};
        end
        else
        begin
            dig_ok  = hexd[4];
            dig     = hexd[3:0];
            shifted = {st.accum, 4'b0000};
        end
        sum        = shifted + {8'd0, dig};
        take       = dig_ok && (st.digits != 2'd0) && (sum <= esc_pkg::VALUE_MAX);
        digits_dec = st.digits - 2'd1;
    end

    // mode handling
    always_comb
    begin
        nxt = st;
        res = '0;
        res.res0.data = in_byte;
        res.res1.data = in_byte;
        unique case (st.mode)
            esc_pkg::MODE_PLAIN:
            begin
                if (in_byte == esc_pkg::CHAR_BSLASH)
                begin
                    if (in_last)
                        res.count = 2'd1;
                    else
                        nxt.mode = esc_pkg::MODE_SLASH;
                end
                else
                    res.count = 2'd1;
            end
            esc_pkg::MODE_SLASH:
            begin
                nxt.mode = esc_pkg::MODE_PLAIN;
                if (named[8])
                begin
                    res.count     = 2'd1;
                    res.res0.data = named[7:0];
                end
                else if (is_oct)
                begin
                    nxt.accum  = {5'd0, in_byte[2:0]};
                    nxt.digits = esc_pkg::DIGITS_MAX;
                    nxt.mode   = esc_pkg::MODE_OCT;
                    res.res0.data = {5'd0, in_byte[2:0]};
                    if (in_last)
                        res.count = 2'd1;
                end
                else if (in_byte == esc_pkg::CHAR_X)
                begin
                    nxt.accum  = 8'd0;
                    nxt.digits = esc_pkg::DIGITS_MAX;
                    nxt.mode   = esc_pkg::MODE_HEX;
                    res.res0.data = 8'd0;
                    if (in_last)
                        res.count = 2'd1;
                end
                else
                    res.count = 2'd1;
            end
            default:
            begin
                if (take)
                begin
                    nxt.accum  = sum[7:0];
                    nxt.digits = digits_dec;
                    res.res0.data = sum[7:0];
                    if (digits_dec == 2'd0 || in_last)
                    begin
                        res.count = 2'd1;
                        nxt.mode  = esc_pkg::MODE_PLAIN;
                    end
                end
                else
                begin
                    // flush the value, then treat the byte as plain text
                    res.res0.data = st.accum;
                    nxt.mode      = esc_pkg::MODE_PLAIN;
                    if (in_byte == esc_pkg::CHAR_BSLASH && !in_last)
                    begin
                        res.count = 2'd1;
                        nxt.mode  = esc_pkg::MODE_SLASH;
                    end
                    else
                        res.count = 2'd2;
                end
            end
        endcase

        // end marks on the final result of this word
        if (res.count == 2'd2)
        begin
            res.res1.run_end    = 1'b1;
            res.res1.string_end = in_last;
        end
        else
        begin
            res.res0.run_end    = 1'b1;
            res.res0.string_end = in_last;
        end

        if (in_last)
            nxt = esc_pkg::STATE_RESET;
    end

    assign st_next = nxt;
    assign push    = res;

endmodule

[rtl/esc_fifo.sv]
// Three-entry result queue: takes up to two words per cycle, gives one.
// Depends on esc_pkg.
module esc_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  esc_pkg::esc_push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output esc_pkg::esc_entry_t out_entry
);

    esc_pkg::esc_entry_t mem_reg [3];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    function automatic logic [1:0] inc3(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    assign pop       = (count_reg != 2'd0) && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_entry = mem_reg[rptr_reg];
    // room for a double result regardless of the output side
    assign room      = (count_reg <= 2'd1);

    // pointer and fill arithmetic
    always_comb
    begin
        wptr_next = wptr_reg;
        if (push.count == 2'd1)
            wptr_next = inc3(wptr_reg);
        else if (push.count == 2'd2)
            wptr_next = inc3(inc3(wptr_reg));
        rptr_next  = pop ? inc3(rptr_reg) : rptr_reg;
        count_next = count_reg + push.count - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // storage writes
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wptr_reg] <= push.res0;
        if (push.count == 2'd2)
            mem_reg[inc3(wptr_reg)] <= push.res1;
    end

endmodule

[rtl/escape_sequence_decoder.sv]
// C escape sequence decoder, top level. Depends on esc_pkg, esc_decode, esc_fifo.
// Each accepted word's results are written into the registered result queue.
// Throughput: one input word per cycle while s_tready is high; a word that yields
// two results (a flushed numeric escape followed by a character) then holds
// s_tready low, as it drops when two or more results wait in the three-entry queue.
// Reset: rst_n clears the decode state to plain text and empties the result queue.
module escape_sequence_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // run_end
    output logic       m_tlast    // string_end
);

    esc_pkg::esc_state_t state_reg, state_next, dec_state;
    esc_pkg::esc_push_t  dec_push, push;
    esc_pkg::esc_entry_t head;
    logic                accept;
    logic                room;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    esc_decode u_decode
    (
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .st      (state_reg),
        .st_next (dec_state),
        .push    (dec_push)
    );

    // only accepted words update state and enter the queue
    always_comb
    begin
        state_next = accept ? dec_state : state_reg;
        push       = dec_push;
        if (!accept)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= esc_pkg::STATE_RESET;
        else
            state_reg <= state_next;
    end

    esc_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (head)
    );

    assign m_tdata = head.data;
    assign m_tuser = head.run_end;
    assign m_tlast = head.string_end;

    // the final word of a string always yields a result
    a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |-> (dec_push.count != 2'd0))
        else $error("string end produced no result");

    // a string end returns the decoder to plain text
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (state_reg.mode == esc_pkg::MODE_PLAIN))
        else $error("decoder not back in plain mode after string end");

    // string end only marks the last result of a word
    a_end_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("string_end without run_end");

endmodule

[tb/escape_sequence_decoder_checker.sv]
// Scoreboard for the escape decoder: predicts decoded words from the input stream
// and compares them with the output stream. Depends on esc_pkg.
module escape_sequence_decoder_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int unsigned error_count,
    output int unsigned pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the decode state
    logic [1:0] mode;
    logic [7:0] accum;
    logic [1:0] digits_left;

    esc_pkg::esc_entry_t word_out [$];
    esc_pkg::esc_entry_t decoded_words [$];
    esc_pkg::esc_entry_t want;

    initial
    begin
        error_count   = 0;
        pending_count = 0;
    end

    task automatic emit_byte(input logic [7:0] v);
        word_out.push_back('{data: v, run_end: 1'b0, string_end: 1'b0});
    endtask

    // ordinary character, or a backslash opening an escape
    task automatic take_plain(input logic [7:0] b, input logic last);
        mode = esc_pkg::MODE_PLAIN;
        if (b == esc_pkg::CHAR_BSLASH)
        begin
            if (last)
                emit_byte(esc_pkg::CHAR_BSLASH);
            else
                mode = esc_pkg::MODE_SLASH;
        end
        else
        begin
            emit_byte(b);
        end
    endtask

    // control code of a named escape, -1 if the letter has none
    function automatic int control_code(input logic [7:0] b);
        case (b)
            "\\":    return 8'h5c;
            "a":     return 8'h07;
            "b":     return 8'h08;
            "e":     return 8'h1b;
            "f":     return 8'h0c;
            "n":     return 8'h0a;
            "r":     return 8'h0d;
            "t":     return 8'h09;
            "v":     return 8'h0b;
            default: return -1;
        endcase
    endfunction

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9")
            return int'(b) - int'("0");
        if (b >= "a" && b <= "f")
            return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F")
            return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    // work out the decoded words caused by one input word
    task automatic predict_word(input logic [7:0] b, input logic last);
        int          code;
        int          dig;
        logic [11:0] scaled;
        word_out.delete();
        case (mode)
            esc_pkg::MODE_PLAIN:
            begin
                take_plain(b, last);
            end
            esc_pkg::MODE_SLASH:
            begin
                code = control_code(b);
                mode = esc_pkg::MODE_PLAIN;
                if (code >= 0)
                begin
                    emit_byte(8'(code));
                end
                else if (b >= esc_pkg::CHAR_ZERO && b <= esc_pkg::CHAR_SEVEN)
                begin
                    accum       = b - esc_pkg::CHAR_ZERO;
                    digits_left = esc_pkg::DIGITS_MAX;
                    mode        = esc_pkg::MODE_OCT;
                    if (last)
                        emit_byte(accum);
                end
                else if (b == esc_pkg::CHAR_X)
                begin
                    accum       = 8'd0;
                    digits_left = esc_pkg::DIGITS_MAX;
                    mode        = esc_pkg::MODE_HEX;
                    if (last)
                        emit_byte(8'd0);
                end
                else
                begin
                    emit_byte(b);
                end
            end
            default:
            begin
                // numeric escape: take the digit if it fits, else flush and go plain
                if (mode == esc_pkg::MODE_OCT)
                begin
                    if (b >= esc_pkg::CHAR_ZERO && b <= esc_pkg::CHAR_SEVEN)
                        dig = int'(b - esc_pkg::CHAR_ZERO);
                    else
                        dig = -1;
                    scaled = {4'd0, accum} << 3;
                end
                else
                begin
                    dig    = hex_digit(b);
                    scaled = {4'd0, accum} << 4;
                end
                if (dig >= 0 && digits_left != 2'd0 &&
                    scaled + 12'(dig) <= esc_pkg::VALUE_MAX)
                begin
                    accum       = 8'(scaled + 12'(dig));
                    digits_left = digits_left - 2'd1;
                    if (digits_left == 2'd0 || last)
                    begin
                        emit_byte(accum);
                        mode = esc_pkg::MODE_PLAIN;
                    end
                end
                else
                begin
                    emit_byte(accum);
                    take_plain(b, last);
                end
            end
        endcase

        if (word_out.size() > 0)
        begin
            word_out[word_out.size() - 1].run_end = 1'b1;
            if (last)
                word_out[word_out.size() - 1].string_end = 1'b1;
        end
        if (last)
        begin
            mode        = esc_pkg::MODE_PLAIN;
            accum       = 8'd0;
            digits_left = 2'd0;
        end
        foreach (word_out[i])
            decoded_words.push_back(word_out[i]);
    endtask

    // predict on input words, compare on output words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode        = esc_pkg::MODE_PLAIN;
            accum       = 8'd0;
            digits_left = 2'd0;
            decoded_words.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_word(s_tdata, s_tlast);

            if (m_tvalid && m_tready)
            begin
                if (decoded_words.size() == 0)
                begin
                    $display("%0t: unexpected word data=%h run_end=%b string_end=%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    error_count++;
                end
                else
                begin
                    want = decoded_words.pop_front();
                    if (m_tdata !== want.data || m_tuser !== want.run_end ||
                        m_tlast !== want.string_end)
                    begin
                        $display({"%0t: expected data=%h run_end=%b string_end=%b, ",
                                  "got data=%h run_end=%b string_end=%b"},
                                 $time, want.data, want.run_end, want.string_end,
                                 m_tdata, m_tuser, m_tlast);
                        error_count++;
                    end
                end
            end
        end
        pending_count = decoded_words.size();
    end

endmodule

[tb/escape_sequence_decoder_test.sv]
// Top of the escape decoder testbench: clock, reset, escaped-string stimulus and
// verdict. Depends on esc_pkg, escape_sequence_decoder and the checker module.
module escape_sequence_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS = 1275;
    localparam int IDLE_LIMIT  = 1000;

    localparam logic [7:0] ESC_LETTERS [9] = '{"\\", "a", "b", "e", "f", "n", "r", "t", "v"};

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    int unsigned error_count;
    int unsigned pending_count;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    bit          calm        = 1'b0;

    escape_sequence_decoder u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    escape_sequence_decoder_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls about 31% of cycles, never during the calm stretch
    always @(negedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 31);
    end

    // watchdog: too long with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[escape_sequence_decoder] ERROR");
            $finish;
        end
    end

    // one input word, with random gaps before it; called at a falling edge
    task automatic send_word(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        calm = (items_sent >= 600 && items_sent < 800);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], i == s.len() - 1);
    endtask

    // random string: mostly well-formed escapes, some noise and loose backslashes
    task automatic send_random_string();
        logic [7:0] text [$];
        int         tokens;
        int         kind;
        int         v;
        logic [7:0] c;
        tokens = $urandom_range(1, 6);
        repeat (tokens)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 25)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == esc_pkg::CHAR_BSLASH)
                    c = "z";
                text.push_back(c);
            end
            else if (kind < 45)
            begin
                text.push_back(esc_pkg::CHAR_BSLASH);
                text.push_back(ESC_LETTERS[$urandom_range(0, 8)]);
            end
            else if (kind < 65)
            begin
                text.push_back(esc_pkg::CHAR_BSLASH);
                repeat ($urandom_range(1, 3))
                    text.push_back(esc_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)));
            end
            else if (kind < 85)
            begin
                text.push_back(esc_pkg::CHAR_BSLASH);
                text.push_back(esc_pkg::CHAR_X);
                repeat ($urandom_range(0, 3))
                begin
                    v = $urandom_range(0, 15);
                    if (v < 10)
                        c = esc_pkg::CHAR_ZERO + 8'(v);
                    else
                        c = ($urandom_range(0, 1) ? "a" : "A") + 8'(v - 10);
                    text.push_back(c);
                end
            end
            else if (kind < 95)
            begin
                text.push_back(esc_pkg::CHAR_BSLASH);
                text.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                text.push_back(esc_pkg::CHAR_BSLASH);
            end
        end
        foreach (text[i])
            send_word(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: byte extremes, zero byte, named escape, octal at the limit and
        // past it, bare hex, hex ended by a non-digit, unknown escape, trailing
        // backslash, octal ended by a new escape
        send_word(8'h01, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h00, 1'b1);
        send_text("\\n");
        send_text("\\377\\400");
        send_text("\\x");
        send_text("\\xfG\\q\\");
        send_text("\\1\\t");

        while (items_sent < TOTAL_ITEMS)
            send_random_string();
        s_tvalid <= 1'b0;

        // drain, then keep the clock running to catch stray words
        while (pending_count != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("[escape_sequence_decoder] OK");
        else
            $display("[escape_sequence_decoder] ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/esc_pkg.sv
rtl/esc_decode.sv
rtl/esc_fifo.sv
rtl/escape_sequence_decoder.sv
tb/escape_sequence_decoder_checker.sv
tb/escape_sequence_decoder_test.sv
